// File: rtl/core/binary_contour_tracer_defines.svh
// Assertion macros shared by the contour tracer RTL.
// No dependencies; the bodies expect clk and rst_n in the using module.
`ifndef BINARY_CONTOUR_TRACER_DEFINES_SVH
`define BINARY_CONTOUR_TRACER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define BCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BCT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BCT_ASSERT_IMP(lbl, ante, cons, msg)

`define BCT_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/core/bct_pkg.sv
// Shared types, constants and direction tables for the contour tracer.
// No dependencies; imported by every module of the block.
package bct_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 128;
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int W_W        = X_W + 1;
    localparam int H_W        = Y_W + 1;
    localparam int ADDR_W     = X_W + Y_W;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int CNT_W      = 16;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 2'd2;

    localparam logic [2:0] DIR_UL = 3'd0;
    localparam logic [2:0] DIR_U  = 3'd1;
    localparam logic [2:0] DIR_UR = 3'd2;
    localparam logic [2:0] DIR_R  = 3'd3;
    localparam logic [2:0] DIR_DR = 3'd4;
    localparam logic [2:0] DIR_D  = 3'd5;
    localparam logic [2:0] DIR_DL = 3'd6;
    localparam logic [2:0] DIR_L  = 3'd7;

    localparam logic [1:0] STEP_NEG  = 2'b11;
    localparam logic [1:0] STEP_ZERO = 2'b00;
    localparam logic [1:0] STEP_POS  = 2'b01;

    typedef enum logic [1:0] {
        REASON_BORDER = 2'd0,
        REASON_LEFT   = 2'd1,
        REASON_NONE   = 2'd2,
        REASON_LIMIT  = 2'd3
    } reason_t;

    typedef struct packed {
        logic             action;
        logic [Y_W-1:0]   row;
        logic [X_W-1:0]   col;
        logic [PIX_W-1:0] pixel;
    } item_t;

    typedef struct packed {
        logic [X_W-1:0] point_x;
        logic [Y_W-1:0] point_y;
        logic           last;
        reason_t        end_reason;
    } point_t;

    typedef struct packed {
        logic [W_W-1:0]   w_eff;
        logic [H_W-1:0]   h_eff;
        logic [CNT_W-1:0] limit;
    } limits_t;

    typedef struct packed {
        logic    wr_pixel;
        logic    run;
        logic    nb_mode;
        logic    load_start;
        logic    found;
        logic    take_step;
        logic    emit;
        logic    last;
        reason_t reason;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic miss;
        logic left;
        logic border;
        logic limit;
    } sts_t;

    function automatic logic [1:0] dir_dx(input logic [2:0] d);
        logic [1:0] r;
        case (d)
            DIR_UL:  r = STEP_NEG;
            DIR_U:   r = STEP_ZERO;
            DIR_UR:  r = STEP_POS;
            DIR_R:   r = STEP_POS;
            DIR_DR:  r = STEP_POS;
            DIR_D:   r = STEP_ZERO;
            DIR_DL:  r = STEP_NEG;
            DIR_L:   r = STEP_NEG;
            default: r = STEP_ZERO;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] dir_dy(input logic [2:0] d);
        logic [1:0] r;
        case (d)
            DIR_UL:  r = STEP_NEG;
            DIR_U:   r = STEP_NEG;
            DIR_UR:  r = STEP_NEG;
            DIR_R:   r = STEP_ZERO;
            DIR_DR:  r = STEP_POS;
            DIR_D:   r = STEP_POS;
            DIR_DL:  r = STEP_POS;
            DIR_L:   r = STEP_ZERO;
            default: r = STEP_ZERO;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/bct_datapath.sv
// Datapath of the contour tracer: bit store, scan address generation and trace state.
// Depends on bct_pkg; driven by bct_ctrl through cmd_t and reports through sts_t.
module bct_datapath
    import bct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  limits_t lim,
    input  cmd_t    cmd,
    output sts_t    sts,
    output point_t  point
);

    logic                mem [DEPTH];

    logic [X_W-1:0]      cx_reg;
    logic [Y_W-1:0]      cy_reg;
    logic [2:0]          back_reg;
    logic                has_prev_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                left_reg;

    logic [X_W-1:0]      sx_reg;
    logic [Y_W-1:0]      sy_reg;
    logic [2:0]          k_reg;
    logic                issue_done_reg;
    logic                iss_reg;

    logic                rd_data_reg;
    logic                inb_reg;
    logic                lastk_reg;
    logic [2:0]          dir_tag_reg;
    logic [X_W-1:0]      px_tag_reg;
    logic [Y_W-1:0]      py_tag_reg;
    point_t              point_reg;

    logic [2:0]          first_dir;
    logic [2:0]          nb_dir;
    logic [W_W-1:0]      nx;
    logic [H_W-1:0]      ny;
    logic                nb_inb;
    logic [W_W-1:0]      w_last;
    logic [H_W-1:0]      h_last;
    logic                start_last;
    logic                issue;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [W_W-1:0]      step_x;
    logic [H_W-1:0]      step_y;
    logic [1:0]          ndx;
    logic [1:0]          ndy;
    logic [1:0]          tdx;
    logic [1:0]          tdy;

    assign w_last    = lim.w_eff - W_W'(1);
    assign h_last    = lim.h_eff - H_W'(1);
    assign first_dir = has_prev_reg ? 3'(back_reg + 3'd1) : DIR_UL;
    assign nb_dir    = 3'(first_dir + k_reg);
    assign ndx       = dir_dx(nb_dir);
    assign ndy       = dir_dy(nb_dir);
    assign nx        = {1'b0, cx_reg} + {{(W_W-2){ndx[1]}}, ndx};
    assign ny        = {1'b0, cy_reg} + {{(H_W-2){ndy[1]}}, ndy};
    assign nb_inb    = (nx < lim.w_eff) && (ny < lim.h_eff);

    assign start_last = ({1'b0, sx_reg} == w_last) && ({1'b0, sy_reg} == h_last);
    assign issue      = cmd.run && !issue_done_reg;
    assign rd_addr    = cmd.nb_mode ? {nx[X_W-1:0], ny[Y_W-1:0]} : {sx_reg, sy_reg};
    assign wr_addr    = {item.col, item.row};

    assign tdx    = dir_dx(dir_tag_reg);
    assign tdy    = dir_dy(dir_tag_reg);
    assign step_x = {1'b0, cx_reg} + {{(W_W-2){tdx[1]}}, tdx};
    assign step_y = {1'b0, cy_reg} + {{(H_W-2){tdy[1]}}, tdy};

    assign sts.hit    = iss_reg && inb_reg && rd_data_reg;
    assign sts.miss   = iss_reg && lastk_reg && !(inb_reg && rd_data_reg);
    assign sts.left   = left_reg;
    assign sts.border = ({1'b0, cx_reg} >= w_last) || ({1'b0, cy_reg} >= h_last);
    assign sts.limit  = count_reg >= lim.limit;

    assign point = point_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_pixel)
        begin
            mem[wr_addr] <= (item.pixel != '0);
        end
        rd_data_reg <= mem[rd_addr];
        inb_reg     <= cmd.nb_mode ? nb_inb : 1'b1;
        lastk_reg   <= cmd.nb_mode ? (k_reg == 3'd7) : start_last;
        dir_tag_reg <= nb_dir;
        px_tag_reg  <= sx_reg;
        py_tag_reg  <= sy_reg;
        if (cmd.emit)
        begin
            point_reg.point_x    <= cx_reg;
            point_reg.point_y    <= cy_reg;
            point_reg.last       <= cmd.last;
            point_reg.end_reason <= cmd.last ? cmd.reason : REASON_BORDER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg         <= '0;
            sy_reg         <= '0;
            k_reg          <= '0;
            issue_done_reg <= 1'b0;
            iss_reg        <= 1'b0;
        end
        else if (!cmd.run)
        begin
            sx_reg         <= '0;
            sy_reg         <= '0;
            k_reg          <= '0;
            issue_done_reg <= 1'b0;
            iss_reg        <= 1'b0;
        end
        else
        begin
            iss_reg <= issue;
            if (issue)
            begin
                if (cmd.nb_mode)
                begin
                    k_reg <= 3'(k_reg + 3'd1);
                    if (k_reg == 3'd7)
                    begin
                        issue_done_reg <= 1'b1;
                    end
                end
                else if ({1'b0, sy_reg} == h_last)
                begin
                    sy_reg <= '0;
                    if ({1'b0, sx_reg} == w_last)
                    begin
                        issue_done_reg <= 1'b1;
                    end
                    else
                    begin
                        sx_reg <= X_W'(sx_reg + 1'b1);
                    end
                end
                else
                begin
                    sy_reg <= Y_W'(sy_reg + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg       <= '0;
            cy_reg       <= '0;
            back_reg     <= '0;
            has_prev_reg <= 1'b0;
            count_reg    <= '0;
            left_reg     <= 1'b0;
        end
        else if (cmd.load_start)
        begin
            cx_reg       <= cmd.found ? px_tag_reg : '0;
            cy_reg       <= cmd.found ? py_tag_reg : '0;
            back_reg     <= '0;
            has_prev_reg <= 1'b0;
            count_reg    <= CNT_W'(1);
            left_reg     <= 1'b0;
        end
        else if (cmd.take_step)
        begin
            cx_reg       <= step_x[X_W-1:0];
            cy_reg       <= step_y[Y_W-1:0];
            back_reg     <= 3'(dir_tag_reg + 3'd4);
            has_prev_reg <= 1'b1;
            if (count_reg != '1)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            left_reg     <= (dir_tag_reg == DIR_L);
        end
    end

endmodule

// File: rtl/core/bct_ctrl.sv
// Controller of the contour tracer: handshakes, trace sequencing and end decisions.
// Depends on bct_pkg and binary_contour_tracer_defines.svh; commands bct_datapath.
`include "binary_contour_tracer_defines.svh"

module bct_ctrl
    import bct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    input  logic action,
    output logic item_stall,
    output logic point_valid,
    input  logic point_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_STEP,
        S_CHECK,
        S_NEXT,
        S_EMIT
    } state_t;

    state_t  state_reg;
    logic    trace_active_reg;
    logic    last_reg;
    reason_t reason_reg;
    logic    valid_reg;
    logic    valid_next;

    logic    accept;
    logic    slot_free;

    assign item_stall  = (state_reg != S_IDLE);
    assign point_valid = valid_reg;
    assign accept      = item_valid && (state_reg == S_IDLE);
    assign slot_free   = !valid_reg || !point_stall;
    assign valid_next  = cmd.emit || (valid_reg && point_stall);

    always_comb
    begin
        cmd            = '0;
        cmd.wr_pixel   = accept && (action == ACT_WRITE);
        cmd.run        = (state_reg == S_START) || (state_reg == S_STEP)
                         || (state_reg == S_NEXT);
        cmd.nb_mode    = (state_reg != S_START);
        cmd.load_start = (state_reg == S_START) && (sts.hit || sts.miss);
        cmd.found      = sts.hit;
        cmd.take_step  = (state_reg == S_STEP) && sts.hit;
        cmd.emit       = (state_reg == S_EMIT) && slot_free;
        cmd.last       = last_reg;
        cmd.reason     = reason_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            trace_active_reg <= 1'b0;
            last_reg         <= 1'b0;
            reason_reg       <= REASON_BORDER;
            valid_reg        <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (action == ACT_REQUEST))
                    begin
                        state_reg <= trace_active_reg ? S_STEP : S_START;
                    end
                end
                S_START:
                begin
                    if (sts.hit || sts.miss)
                    begin
                        trace_active_reg <= 1'b1;
                        state_reg        <= S_CHECK;
                    end
                end
                S_STEP:
                begin
                    if (sts.hit)
                    begin
                        state_reg <= S_CHECK;
                    end
                    else if (sts.miss)
                    begin
                        last_reg   <= 1'b1;
                        reason_reg <= REASON_NONE;
                        state_reg  <= S_EMIT;
                    end
                end
                S_CHECK:
                begin
                    if (sts.left)
                    begin
                        last_reg   <= 1'b1;
                        reason_reg <= REASON_LEFT;
                        state_reg  <= S_EMIT;
                    end
                    else if (sts.border)
                    begin
                        last_reg   <= 1'b1;
                        reason_reg <= REASON_BORDER;
                        state_reg  <= S_EMIT;
                    end
                    else if (sts.limit)
                    begin
                        last_reg   <= 1'b1;
                        reason_reg <= REASON_LIMIT;
                        state_reg  <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (sts.hit)
                    begin
                        last_reg   <= 1'b0;
                        reason_reg <= REASON_BORDER;
                        state_reg  <= S_EMIT;
                    end
                    else if (sts.miss)
                    begin
                        last_reg   <= 1'b1;
                        reason_reg <= REASON_NONE;
                        state_reg  <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        if (last_reg)
                        begin
                            trace_active_reg <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `BCT_ASSERT_NXT(a_emit_shows, cmd.emit, valid_reg, "emitted point not presented")
    `BCT_ASSERT_IMP(a_start_new, state_reg == S_START, !trace_active_reg, "restart in a trace")
    `BCT_ASSERT_IMP(a_step_active, cmd.run && cmd.nb_mode, trace_active_reg, "scan with no trace")
    `BCT_ASSERT_NXT(a_last_ends, cmd.emit && cmd.last, !trace_active_reg, "trace still active")

endmodule

// File: rtl/core/binary_contour_tracer.sv
// Top level of the binary contour tracer: configuration registers and block wiring.
// Depends on bct_pkg, bct_ctrl and bct_datapath.
//
// Pixel writes are accepted while the controller is idle. A point request runs through the
// control states and makes the reads it needs from the bit store, one read a cycle: a
// following point costs up to eight reads to find the step and up to eight more to check
// that the new point has a neighbour. The first request of a trace searches the image
// column by column, one pixel a cycle, until the first foreground pixel. The bit store is
// never cleared; every pixel in use must be written before tracing. Configuration is
// accepted on every cycle.
module binary_contour_tracer
    import bct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  point_valid,
    input  logic                  point_stall,
    output point_t                point,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [W_W-1:0]   width_reg;
    logic [H_W-1:0]   height_reg;
    logic [CNT_W-1:0] max_reg;
    limits_t          lim;
    cmd_t             cmd;
    sts_t             sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= W_W'(MAX_WIDTH);
            height_reg <= H_W'(MAX_HEIGHT);
            max_reg    <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[W_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[H_W-1:0];
                CFG_MAX:    max_reg    <= cfg_data[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < W_W'(2))
        begin
            lim.w_eff = W_W'(2);
        end
        else if (width_reg > W_W'(MAX_WIDTH))
        begin
            lim.w_eff = W_W'(MAX_WIDTH);
        end
        else
        begin
            lim.w_eff = width_reg;
        end
        if (height_reg < H_W'(2))
        begin
            lim.h_eff = H_W'(2);
        end
        else if (height_reg > H_W'(MAX_HEIGHT))
        begin
            lim.h_eff = H_W'(MAX_HEIGHT);
        end
        else
        begin
            lim.h_eff = height_reg;
        end
        lim.limit = (max_reg == '0) ? CNT_W'(1) : max_reg;
    end

    bct_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .action      (item.action),
        .item_stall  (item_stall),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    bct_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .lim   (lim),
        .cmd   (cmd),
        .sts   (sts),
        .point (point)
    );

endmodule

// File: sim/binary_contour_tracer_test.sv
// Self-checking test of binary_contour_tracer: loads images, traces their contours and checks
// every returned point against a behavioural predictor held in this module.
// Depends on bct_pkg and the RTL of the block; needs no files and no arguments.
module binary_contour_tracer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bct_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int CNT_SAT = 65535;
    localparam int ITEM_W = $bits(item_t);

    typedef enum int {ART_EMPTY, ART_NOISE, ART_BLOCK, ART_SOLID} art_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    item_t item = '0;
    logic point_valid;
    logic point_stall = 1'b0;
    point_t point;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    item_t pending_items[$];
    point_t expected_points[$];
    int items_queued = 0;
    int items_taken = 0;
    int mismatches = 0;

    bit ink_map [DEPTH];
    logic [W_W-1:0] width_reg = W_W'(MAX_WIDTH);
    logic [H_W-1:0] height_reg = H_W'(MAX_HEIGHT);
    logic [CNT_W-1:0] max_reg = CNT_W'(CNT_SAT);
    int cur_x = 0;
    int cur_y = 0;
    int back_dir = 0;
    int n_points = 0;
    bit has_prev = 1'b0;
    bit tracing = 1'b0;

    int item_gap = 0;
    bit item_calm = 1'b0;
    int hold = 0;
    bit result_calm = 1'b0;

    binary_contour_tracer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    function automatic int span_w();
        if (int'(width_reg) < 2)
            return 2;
        if (int'(width_reg) > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int span_h();
        if (int'(height_reg) < 2)
            return 2;
        if (int'(height_reg) > MAX_HEIGHT)
            return MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    function automatic int step_x(logic [2:0] d);
        case (d)
            DIR_UR, DIR_R, DIR_DR: return 1;
            DIR_UL, DIR_DL, DIR_L: return -1;
            default: return 0;
        endcase
    endfunction

    function automatic int step_y(logic [2:0] d);
        case (d)
            DIR_DR, DIR_D, DIR_DL: return 1;
            DIR_UL, DIR_U, DIR_UR: return -1;
            default: return 0;
        endcase
    endfunction

    function automatic bit ink_at(int x, int y);
        if (x < 0 || y < 0 || x >= span_w() || y >= span_h())
            return 1'b0;
        return ink_map[y * MAX_WIDTH + x];
    endfunction

    // Clockwise search from the direction after the back-pointer; -1 when isolated.
    function automatic int next_dir();
        int first_dir;
        int d;
        first_dir = has_prev ? ((back_dir + 1) & 7) : 0;
        for (int k = 0; k < 8; k++)
        begin
            d = (first_dir + k) & 7;
            if (ink_at(cur_x + step_x(3'(d)), cur_y + step_y(3'(d))))
                return d;
        end
        return -1;
    endfunction

    function automatic void push_point(bit fin, reason_t why);
        point_t p;
        p.point_x = X_W'(cur_x);
        p.point_y = Y_W'(cur_y);
        p.last = fin;
        p.end_reason = fin ? why : REASON_BORDER;
        if (fin)
            tracing = 1'b0;
        expected_points.insert(expected_points.size(), p);
    endfunction

    function automatic void follow_item(item_t it);
        int d;
        int cap;
        bit left_step;
        bit found;
        if (it.action == ACT_WRITE)
        begin
            ink_map[int'(it.row) * MAX_WIDTH + int'(it.col)] = (it.pixel != '0);
            return;
        end
        left_step = 1'b0;
        if (!tracing)
        begin
            found = 1'b0;
            cur_x = 0;
            cur_y = 0;
            for (int x = 0; x < span_w() && !found; x++)
                for (int y = 0; y < span_h() && !found; y++)
                    if (ink_at(x, y))
                    begin
                        cur_x = x;
                        cur_y = y;
                        found = 1'b1;
                    end
            back_dir = 0;
            has_prev = 1'b0;
            n_points = 1;
            tracing = 1'b1;
        end
        else
        begin
            d = next_dir();
            if (d < 0)
            begin
                push_point(1'b1, REASON_NONE);
                return;
            end
            cur_x = (cur_x + step_x(3'(d))) & (MAX_WIDTH - 1);
            cur_y = (cur_y + step_y(3'(d))) & (MAX_HEIGHT - 1);
            back_dir = (d + 4) & 7;
            has_prev = 1'b1;
            if (n_points < CNT_SAT)
                n_points++;
            left_step = (3'(d) == DIR_L);
        end
        cap = (max_reg == '0) ? 1 : int'(max_reg);
        if (left_step)
            push_point(1'b1, REASON_LEFT);
        else if (cur_x >= span_w() - 1 || cur_y >= span_h() - 1)
            push_point(1'b1, REASON_BORDER);
        else if (n_points >= cap)
            push_point(1'b1, REASON_LIMIT);
        else if (next_dir() < 0)
            push_point(1'b1, REASON_NONE);
        else
            push_point(1'b0, REASON_BORDER);
    endfunction

    function automatic void compare_field(string name, logic [X_W-1:0] want,
                                          logic [X_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int idle_span(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic put_pixel(int r, int c, bit ink);
        item_t it;
        it.action = ACT_WRITE;
        it.row = Y_W'(r);
        it.col = X_W'(c);
        it.pixel = ink ? PIX_W'($urandom_range(1, 255)) : '0;
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endtask

    task automatic ask_points(int n);
        item_t it;
        repeat (n)
        begin
            it = ITEM_W'($urandom);
            it.action = ACT_REQUEST;
            pending_items.insert(pending_items.size(), it);
            items_queued++;
        end
    endtask

    task automatic paint(art_t art);
        int w;
        int h;
        int x0;
        int x1;
        int y0;
        int y1;
        int density;
        bit ink;
        w = span_w();
        h = span_h();
        x0 = $urandom_range(0, w - 1);
        x1 = $urandom_range(x0, w - 1);
        y0 = $urandom_range(0, h - 1);
        y1 = $urandom_range(y0, h - 1);
        density = $urandom_range(5, 60);
        for (int c = 0; c < w; c++)
            for (int r = 0; r < h; r++)
            begin
                case (art)
                    ART_EMPTY: ink = 1'b0;
                    ART_NOISE: ink = ($urandom_range(0, 99) < density);
                    ART_BLOCK: ink = (c >= x0 && c <= x1 && r >= y0 && r <= y1);
                    default: ink = 1'b1;
                endcase
                put_pixel(r, c, ink);
            end
    endtask

    task automatic drain();
        while (items_taken != items_queued || expected_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_area(int w, int h, int m);
        drain();
        repeat (40) @(posedge clk);
        cfg_write(CFG_WIDTH, CFG_DATA_W'(($urandom << W_W) | w));
        cfg_write(CFG_HEIGHT, CFG_DATA_W'(($urandom << H_W) | h));
        cfg_write(CFG_MAX, CFG_DATA_W'(m));
    endtask

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item_gap <= 0;
        end
        else if (!item_valid || !item_stall)
        begin
            if ($urandom_range(0, 63) == 0)
                item_calm <= !item_calm;
            if (item_gap > 0)
            begin
                item_valid <= 1'b0;
                item_gap <= item_gap - 1;
            end
            else if (pending_items.size() > 0)
            begin
                item <= pending_items.pop_front();
                item_valid <= 1'b1;
                item_gap <= idle_span(item_calm);
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_stall <= 1'b0;
            hold <= 0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                result_calm <= !result_calm;
            if (hold > 0)
            begin
                point_stall <= 1'b1;
                hold <= hold - 1;
            end
            else
            begin
                point_stall <= 1'b0;
                hold <= idle_span(result_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
        begin
            follow_item(item);
            items_taken++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIDTH: width_reg = cfg_data[W_W-1:0];
                CFG_HEIGHT: height_reg = cfg_data[H_W-1:0];
                CFG_MAX: max_reg = cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin : check_points
        point_t want;
        if (rst_n && point_valid && !point_stall)
        begin
            if (expected_points.size() == 0)
            begin
                $error("point (%0d,%0d) arrived with none expected",
                       point.point_x, point.point_y);
                mismatches++;
            end
            else
            begin
                want = expected_points.pop_front();
                compare_field("point_x", want.point_x, point.point_x);
                compare_field("point_y", X_W'(want.point_y), X_W'(point.point_y));
                compare_field("last", X_W'(want.last), X_W'(point.last));
                compare_field("end_reason", X_W'(want.end_reason), X_W'(point.end_reason));
            end
        end
    end

    initial
    begin
        int base;
        int w;
        int h;
        int m;
        int n;
        int pick;
        art_t art;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_area(4, 4, CNT_SAT);
        paint(ART_EMPTY);
        ask_points(2);
        put_pixel(1, 1, 1'b1);
        ask_points(1);
        put_pixel(1, 2, 1'b1);
        ask_points(3);
        ask_points(1);
        put_pixel(1, 2, 1'b0);
        ask_points(1);

        set_area(4, 4, 3);
        put_pixel(1, 2, 1'b1);
        ask_points(3);

        set_area(4, 4, 1);
        paint(ART_EMPTY);
        put_pixel(3, 0, 1'b1);
        ask_points(1);

        set_area(6, 5, 1);
        paint(ART_SOLID);
        ask_points(2);

        set_area(0, 1, 0);
        paint(ART_SOLID);
        ask_points(2);

        set_area(5, 5, CNT_SAT);
        paint(ART_SOLID);
        ask_points(6);

        // The trace stays within the first two columns; only the first four columns are loaded.
        set_area(2047, 2, 40);
        for (int c = 0; c < 4; c++)
        begin
            put_pixel(0, c, c == 0);
            put_pixel(1, c, c == 1);
        end
        ask_points(4);
        set_area(MAX_WIDTH, 2, 40);
        ask_points(4);

        set_area(2, 255, CNT_SAT);
        paint(ART_NOISE);
        ask_points(8);
        set_area(2, MAX_HEIGHT, 7);
        ask_points(3);

        drain();
        repeat (40) @(posedge clk);
        cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));

        base = items_queued;
        set_area(8, 6, CNT_SAT);
        while (items_queued - base < 500)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(2, 16);
                h = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 32) : $urandom_range(2, 12);
                if ($urandom_range(0, 15) == 0)
                    w = $urandom_range(0, 1);
                if ($urandom_range(0, 15) == 0)
                    h = $urandom_range(0, 1);
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    m = 0;
                else if (pick < 4)
                    m = $urandom_range(1, 20);
                else if (pick < 6)
                    m = $urandom_range(21, CNT_SAT);
                else
                    m = CNT_SAT;
                set_area(w, h, m);
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
                art = ART_BLOCK;
            else if (pick < 80)
                art = ART_NOISE;
            else if (pick < 85)
                art = ART_EMPTY;
            else
                art = ART_SOLID;
            paint(art);
            n = $urandom_range(4, 30);
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                    put_pixel($urandom_range(0, span_h() - 1), $urandom_range(0, span_w() - 1),
                              1'($urandom_range(0, 1)));
                ask_points(1);
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("[binary_contour_tracer] OK");
        else
            $display("[binary_contour_tracer] ERROR");
        $finish;
    end

    initial
    begin
        #(200_000_000);
        $display("[binary_contour_tracer] ERROR");
        $finish;
    end

endmodule
